FILE: rtl/core/deq_pkg.sv
package deq_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int DATA_W           = 32;
   localparam int OP_W             = 3;
   localparam int STATUS_W         = 2;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_DUMP,
      FSM_DRAIN
   } fsm_type;

endpackage

FILE: rtl/core/deq_ram.sv
module deq_ram import deq_pkg::*; #(
   parameter int DEPTH = CAPACITY_DEFAULT,
   parameter int AW    = $clog2(CAPACITY_DEFAULT)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/deq_ctrl.sv
module deq_ctrl import deq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int AW       = $clog2(CAPACITY_DEFAULT),
   parameter int CW       = $clog2(CAPACITY_DEFAULT + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [OP_W-1:0]            req_op,
   input  logic signed [DATA_W-1:0]   req_item,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0]   rsp_value,
   output logic                       rsp_last,
   output logic                       mem_wr_en,
   output logic [AW-1:0]              mem_wr_addr,
   output logic signed [DATA_W-1:0]   mem_wr_data,
   output logic                       mem_rd_en,
   output logic [AW-1:0]              mem_rd_addr,
   input  logic signed [DATA_W-1:0]   mem_rd_data
);

   localparam int SW = CW + 1;

   fsm_type                   state_ff, state_in;
   logic [AW-1:0]             front_ff, front_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic                      rd_pend_ff, rd_pend_in;
   logic                      rd_last_ff, rd_last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic          full, empty;
   logic [AW-1:0] front_dec, front_inc, rear_pos, rear_last, dump_pos;

   // Fold a ring position below twice the capacity back into the ring.
   function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] pos);
      logic [SW-1:0] red;
      red = (pos >= SW'(CAPACITY)) ? pos - SW'(CAPACITY) : pos;
      return red[AW-1:0];
   endfunction

   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? AW'(CAPACITY - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(CAPACITY - 1)) ? '0 : front_ff + AW'(1);
   assign rear_pos  = ring_wrap(SW'(front_ff) + SW'(count_ff));
   assign rear_last = ring_wrap(SW'(front_ff) + SW'(count_ff) - SW'(1));
   assign dump_pos  = ring_wrap(SW'(front_ff) + SW'(idx_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rd_pend_ff   <= rd_pend_in;
         rd_last_ff   <= rd_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      rd_pend_in  = 1'b0;
      rd_last_in  = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = rear_pos;
      mem_wr_data = req_item;
      mem_rd_en   = 1'b0;
      mem_rd_addr = dump_pos;
      // a read issued last cycle turns into a result transfer now
      rsp_valid_in  = rd_pend_ff;
      rsp_status_in = STATUS_OK;
      rsp_value_in  = rd_pend_ff ? mem_rd_data : '0;
      rsp_last_in   = rd_last_ff;

      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               case (req_op)
                  OP_PUSH_FRONT, OP_PUSH_REAR: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                        if (req_op == OP_PUSH_FRONT) begin
                           mem_wr_addr = front_dec;
                           front_in    = front_dec;
                        end
                     end
                  end
                  OP_POP_FRONT, OP_POP_REAR: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_last_in   = 1'b1;
                     end else begin
                        mem_rd_en  = 1'b1;
                        rd_pend_in = 1'b1;
                        rd_last_in = 1'b1;
                        count_in   = count_ff - CW'(1);
                        state_in   = FSM_DRAIN;
                        if (req_op == OP_POP_FRONT) begin
                           mem_rd_addr = front_ff;
                           front_in    = front_inc;
                        end else begin
                           mem_rd_addr = rear_last;
                        end
                     end
                  end
                  OP_DUMP: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_last_in   = 1'b1;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = front_ff;
                        rd_pend_in  = 1'b1;
                        rd_last_in  = (count_ff == CW'(1));
                        idx_in      = CW'(1);
                        state_in    = (count_ff == CW'(1)) ? FSM_DRAIN : FSM_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         FSM_DUMP: begin
            mem_rd_en  = 1'b1;
            rd_pend_in = 1'b1;
            rd_last_in = (idx_ff == count_ff - CW'(1));
            idx_in     = idx_ff + CW'(1);
            if (rd_last_in) begin
               state_in = FSM_DRAIN;
            end
         end
         FSM_DRAIN: begin
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != FSM_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: rtl/core/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit items held in a ring of CAPACITY
// entries in one synchronous RAM. Issue a request by raising start while busy is
// low. A push leaves busy low, so the block is ready again at once; a pop holds
// busy while the RAM read completes, and a dump holds busy while it issues one
// RAM read per stored item. A read result is registered in the RAM and then on
// the rsp_ ports; an answer with no read is registered from the request. Each
// result is held for a single cycle with rsp_valid high; the receiver must take
// every transfer as it comes. Pushing while full answers status full, popping or
// dumping while empty answers status empty; op codes 5 to 7 give no result.
module double_ended_queue import deq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [OP_W-1:0]            req_op,
   input  logic signed [DATA_W-1:0]   req_item,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0]   rsp_value,
   output logic                       rsp_last
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic                      mem_wr_en;
   logic [AW-1:0]             mem_wr_addr;
   logic signed [DATA_W-1:0]  mem_wr_data;
   logic                      mem_rd_en;
   logic [AW-1:0]             mem_rd_addr;
   logic signed [DATA_W-1:0]  mem_rd_data;

   deq_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_op      (req_op),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   deq_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   a_push_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_PUSH_FRONT || req_op == OP_PUSH_REAR))
      |=> (rsp_valid && rsp_last && !busy))
      else $error("push did not answer in the next cycle");

   a_pop_holds_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && mem_rd_en) |=> busy)
      else $error("read issued without holding busy");

   a_no_wr_rd_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("RAM written and read in the same cycle");

   a_error_status_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_value == '0 && rsp_last))
      else $error("error status with data or without last");

endmodule

FILE: verif/deq_checker.sv
`timescale 1ns / 1ps

module deq_checker import deq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [OP_W-1:0]          req_op,
   input  logic signed [DATA_W-1:0] req_item,
   input  logic                     rsp_valid,
   input  logic [STATUS_W-1:0]      rsp_status,
   input  logic signed [DATA_W-1:0] rsp_value,
   input  logic                     rsp_last,
   output int                       errors,
   output int                       pending,
   output int                       results_seen,
   output int                       full_seen,
   output int                       empty_seen,
   output int                       dump_seen
);

   localparam int DEPTH = CAPACITY_DEFAULT;
   localparam int IDX_W = $clog2(DEPTH);

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [DATA_W-1:0] value;
      logic                    last;
   } deq_result_type;

   logic signed [DATA_W-1:0] ring [DEPTH];
   logic [IDX_W-1:0]         head;
   logic [IDX_W:0]           fill;
   deq_result_type           expected_results[$];

   int err_cnt    = 0;
   int result_cnt = 0;
   int full_cnt   = 0;
   int empty_cnt  = 0;
   int dump_cnt   = 0;

   function automatic void queue_result(input logic [STATUS_W-1:0] status,
                                        input logic signed [DATA_W-1:0] value,
                                        input logic last);
      deq_result_type r;
      r.status = status;
      r.value  = value;
      r.last   = last;
      expected_results.push_back(r);
   endfunction

   // Update the shadow ring for one accepted request and queue what it answers.
   task automatic apply_request(input logic [OP_W-1:0] op,
                                input logic signed [DATA_W-1:0] item);
      int k;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (fill == (IDX_W+1)'(DEPTH)) begin
               queue_result(STATUS_FULL, '0, 1'b1);
            end else begin
               if (op == OP_PUSH_FRONT) begin
                  head = head - 1'b1;
                  ring[head] = item;
               end else begin
                  ring[IDX_W'(head + fill)] = item;
               end
               fill = fill + 1'b1;
               queue_result(STATUS_OK, '0, 1'b1);
            end
         end
         OP_POP_FRONT: begin
            if (fill == '0) begin
               queue_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               queue_result(STATUS_OK, ring[head], 1'b1);
               head = head + 1'b1;
               fill = fill - 1'b1;
            end
         end
         OP_POP_REAR: begin
            if (fill == '0) begin
               queue_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               queue_result(STATUS_OK, ring[IDX_W'(head + fill - 1'b1)], 1'b1);
               fill = fill - 1'b1;
            end
         end
         OP_DUMP: begin
            if (fill == '0) begin
               queue_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (k = 0; k < int'(fill); k++) begin
                  queue_result(STATUS_OK, ring[IDX_W'(head + k)], k == int'(fill) - 1);
               end
               dump_cnt += int'(fill);
            end
         end
         default: ;  // spare op codes answer nothing
      endcase
   endtask

   always @(posedge clock) begin : watch
      deq_result_type want;
      if (reset) begin
         head = '0;
         fill = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid) begin
            result_cnt++;
            if (rsp_status == STATUS_FULL) full_cnt++;
            if (rsp_status == STATUS_EMPTY) empty_cnt++;
            if (expected_results.size() == 0) begin
               $error("unexpected result: status %0d value %0d last %0d",
                      rsp_status, rsp_value, rsp_last);
               err_cnt++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status mismatch: expected %0d, got %0d",
                         want.status, rsp_status);
                  err_cnt++;
               end
               if (rsp_value !== want.value) begin
                  $error("rsp_value mismatch: expected %0d, got %0d",
                         want.value, rsp_value);
                  err_cnt++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last mismatch: expected %0d, got %0d",
                         want.last, rsp_last);
                  err_cnt++;
               end
            end
         end
         if (start && !busy) apply_request(req_op, req_item);
      end
      errors       <= err_cnt;
      pending      <= expected_results.size();
      results_seen <= result_cnt;
      full_seen    <= full_cnt;
      empty_seen   <= empty_cnt;
      dump_seen    <= dump_cnt;
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import deq_pkg::*;

   localparam logic [OP_W-1:0] OP_RESERVED_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_RESERVED_7 = 3'd7;
   localparam int RANDOM_ITEMS  = 140;
   localparam int QUIET_TAIL    = 40;
   localparam int SETTLE_CYCLES = 24;
   localparam logic signed [DATA_W-1:0] ITEM_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] ITEM_MIN = 32'sh8000_0000;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic                     clock    = 1'b0;
   logic                     reset    = 1'b1;
   logic                     start    = 1'b0;
   logic [OP_W-1:0]          req_op   = '0;
   logic signed [DATA_W-1:0] req_item = '0;
   logic                     busy;
   logic                     rsp_valid;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_value;
   logic                     rsp_last;

   int errors, pending, results_seen, full_seen, empty_seen, dump_seen;
   int requests = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   double_ended_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_op     (req_op),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_last)
   );

   deq_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_value    (rsp_value),
      .rsp_last     (rsp_last),
      .errors       (errors),
      .pending      (pending),
      .results_seen (results_seen),
      .full_seen    (full_seen),
      .empty_seen   (empty_seen),
      .dump_seen    (dump_seen)
   );

   // Hold the request until the transfer, then maybe leave a gap.
   task automatic issue(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] item,
                        input bit quiet);
      start    <= 1'b1;
      req_op   <= op;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      requests++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   function automatic logic signed [DATA_W-1:0] rand_item();
      case ($urandom_range(0, 9))
         0:       return ITEM_MAX;
         1:       return ITEM_MIN;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input mix_type mix);
      int r;
      int push_pct;
      r = $urandom_range(0, 99);
      push_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 25 : 48;
      if (r < 4) return OP_RESERVED_5 + OP_W'($urandom_range(0, 2));
      if (r < 14) return OP_DUMP;
      if ($urandom_range(0, 99) < push_pct)
         return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
   endfunction

   initial begin
      int counted;
      int k;
      mix_type mix;
      logic [OP_W-1:0] op;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty queue answers, then both ends and the value extremes
      issue(OP_DUMP, '0, 1'b0);
      issue(OP_POP_FRONT, -1, 1'b0);
      issue(OP_POP_REAR, ITEM_MAX, 1'b0);
      issue(OP_PUSH_FRONT, ITEM_MAX, 1'b0);
      issue(OP_PUSH_REAR, ITEM_MIN, 1'b0);
      issue(OP_PUSH_FRONT, -1, 1'b0);
      issue(OP_PUSH_REAR, '0, 1'b0);
      issue(OP_DUMP, ITEM_MIN, 1'b0);
      issue(OP_POP_FRONT, '0, 1'b0);
      issue(OP_POP_REAR, '0, 1'b0);
      issue(OP_RESERVED_5, ITEM_MIN, 1'b0);
      issue(OP_RESERVED_7, ITEM_MAX, 1'b0);
      // fill to capacity, refuse at both ends, dump the full ring
      for (k = 0; k < CAPACITY_DEFAULT - 2; k++)
         issue(k[0] ? OP_PUSH_FRONT : OP_PUSH_REAR, $urandom, 1'b0);
      issue(OP_PUSH_FRONT, ITEM_MAX, 1'b0);
      issue(OP_PUSH_REAR, ITEM_MIN, 1'b0);
      issue(OP_DUMP, '0, 1'b0);

      counted = 0;
      mix = MIX_FILL;
      while (counted < RANDOM_ITEMS) begin
         if (counted % 16 == 0) mix = mix_type'($urandom_range(0, 2));
         op = pick_op(mix);
         issue(op, rand_item(), counted >= RANDOM_ITEMS - QUIET_TAIL);
         if (op <= OP_DUMP) counted++;
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending != 0) $error("%0d expected results never arrived", pending);

      $display("Ran %0d requests, %0d results: %0d full refusals, %0d empty answers, %0d dumped",
               requests, results_seen, full_seen, empty_seen, dump_seen);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("timeout waiting for the queue");
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/double_ended_queue.sv
verif/deq_checker.sv
verif/tb.sv
